[rtl/core/pfpp_pkg.sv]
// Package for the packet fragmenting payload packer.
// Holds the operation codes, queue sizes, the queue entry type and the result type; no dependencies.
package pfpp_pkg;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_ASSEMBLE = 1'b1;

  localparam logic [2:0] REG_PKT_LIMIT     = 3'd0;
  localparam logic [2:0] REG_MIN_PARTITION = 3'd1;

  localparam int PACKET_QUEUE_DEPTH   = 16;
  localparam int FRAGMENT_QUEUE_DEPTH = 16;

  localparam logic [15:0] HEADER_BYTES = 16'd8;

  typedef struct packed {
    logic [15:0] len;
    logic [31:0] id;
    logic [7:0]  frag;
    logic        last;
    logic [3:0]  slot;
    logic [15:0] offset;
  } entry_t;

  // One decoded command from the front part.
  typedef struct packed {
    logic        op;
    entry_t      pkt;
    logic [15:0] psize;
  } cmd_t;

  typedef struct packed {
    logic        segment_valid;
    logic [3:0]  src_slot;
    logic [15:0] src_offset;
    logic [15:0] seg_length;
    logic [31:0] seg_id;
    logic [7:0]  seg_frag_num;
    logic        seg_last;
    logic [15:0] dest_offset;
    logic [15:0] bytes_used;
    logic [15:0] useful_size;
    logic        accepted;
    logic        last_result;
  } result_t;

endpackage

[rtl/core/pfpp_if.sv]
// Valid/ready channel interfaces for the packer.
// Depends on nothing but the field widths of the work items.
interface pfpp_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] pkt_length;
  logic [31:0] pkt_id;
  logic [7:0]  pkt_frag_num;
  logic        pkt_last;
  logic [3:0]  pkt_slot;
  logic [15:0] partition_size;
  modport source (output valid, operation, pkt_length, pkt_id, pkt_frag_num, pkt_last,
                  pkt_slot, partition_size, input ready);
  modport sink (input valid, operation, pkt_length, pkt_id, pkt_frag_num, pkt_last,
                pkt_slot, partition_size, output ready);
endinterface

interface pfpp_out_if;
  logic        valid;
  logic        ready;
  logic        segment_valid;
  logic [3:0]  src_slot;
  logic [15:0] src_offset;
  logic [15:0] seg_length;
  logic [31:0] seg_id;
  logic [7:0]  seg_frag_num;
  logic        seg_last;
  logic [15:0] dest_offset;
  logic [15:0] bytes_used;
  logic [15:0] useful_size;
  logic        accepted;
  logic        last_result;
  modport source (output valid, segment_valid, src_slot, src_offset, seg_length, seg_id,
                  seg_frag_num, seg_last, dest_offset, bytes_used, useful_size, accepted,
                  last_result, input ready);
  modport sink (input valid, segment_valid, src_slot, src_offset, seg_length, seg_id,
                seg_frag_num, seg_last, dest_offset, bytes_used, useful_size, accepted,
                last_result, output ready);
endinterface

[rtl/core/pfpp_front.sv]
// Front part: takes input transfers into a two-entry command queue.
// Depends on pfpp_pkg and pfpp_in_if.
module pfpp_front (
  input  logic              clk,
  input  logic              rst,
  pfpp_in_if.sink           in_ch,
  output logic              cmd_valid,
  output pfpp_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  pfpp_pkg::cmd_t q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  logic       push;
  pfpp_pkg::cmd_t incoming;

  always_comb begin
    incoming.op         = in_ch.operation;
    incoming.pkt.len    = in_ch.pkt_length;
    incoming.pkt.id     = in_ch.pkt_id;
    incoming.pkt.frag   = in_ch.pkt_frag_num;
    incoming.pkt.last   = in_ch.pkt_last;
    incoming.pkt.slot   = in_ch.pkt_slot;
    incoming.pkt.offset = '0;
    incoming.psize      = in_ch.partition_size;
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= incoming;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("command queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2 && !cmd_pop) |=> count == 2'd2)
    else $error("full command queue changed without a pop");

endmodule

[rtl/core/pfpp_back.sv]
// Back part: packet and fragment queues and the assembly sequencer.
// Depends on pfpp_pkg and pfpp_out_if.
module pfpp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic [4:0]     pkt_limit,
  input  logic [15:0]    min_partition_size,
  input  logic           cmd_valid,
  input  pfpp_pkg::cmd_t cmd,
  output logic           cmd_pop,
  pfpp_out_if.source     out_ch
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  pfpp_pkg::entry_t pq [pfpp_pkg::PACKET_QUEUE_DEPTH];
  pfpp_pkg::entry_t fq [pfpp_pkg::FRAGMENT_QUEUE_DEPTH];

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [3:0]  p_head;
  logic [4:0]  p_count;
  logic [3:0]  f_head;
  logic [4:0]  f_count;
  logic [15:0] data;
  logic [15:0] maxp;
  logic [15:0] useful;
  pfpp_pkg::entry_t p_rd, f_rd;
  pfpp_pkg::result_t res, res_next;
  pfpp_pkg::result_t pend, pend_next;
  pfpp_pkg::result_t seg;
  logic        res_valid, res_valid_next;
  logic        pend_full, pend_full_next;

  logic        pq_we, fq_we;
  logic [3:0]  pq_wa, fq_wa;
  pfpp_pkg::entry_t fq_wd;

  logic        enq_go, asm_go, step_fire;
  logic        use_frag, have_item, room;
  pfpp_pkg::entry_t cur;
  logic [16:0] fit_end, hdr_end;
  logic        fits, no_hdr, frag_full;
  logic [15:0] plen;
  logic        p_ok;
  logic        step_seg, step_end, pop_pkt, pop_frag, push_frag;

  assign out_ch.valid         = res_valid;
  assign out_ch.segment_valid = res.segment_valid;
  assign out_ch.src_slot      = res.src_slot;
  assign out_ch.src_offset    = res.src_offset;
  assign out_ch.seg_length    = res.seg_length;
  assign out_ch.seg_id        = res.seg_id;
  assign out_ch.seg_frag_num  = res.seg_frag_num;
  assign out_ch.seg_last      = res.seg_last;
  assign out_ch.dest_offset   = res.dest_offset;
  assign out_ch.bytes_used    = res.bytes_used;
  assign out_ch.useful_size   = res.useful_size;
  assign out_ch.accepted      = res.accepted;
  assign out_ch.last_result   = res.last_result;

  assign enq_go    = (state == S_IDLE) && cmd_valid && !res_valid &&
                     (cmd.op == pfpp_pkg::OP_ENQUEUE);
  assign asm_go    = (state == S_IDLE) && cmd_valid && !res_valid &&
                     (cmd.op == pfpp_pkg::OP_ASSEMBLE);
  assign step_fire = (state == S_STEP) && !res_valid;

  assign p_ok      = (p_count < pkt_limit) &&
                     (p_count < 5'(pfpp_pkg::PACKET_QUEUE_DEPTH));
  assign use_frag  = (f_count != 5'd0);
  assign have_item = use_frag || (p_count != 5'd0);
  assign room      = (data < maxp);
  assign cur       = use_frag ? f_rd : p_rd;
  assign fit_end   = {1'b0, data} + {1'b0, cur.len} + {1'b0, pfpp_pkg::HEADER_BYTES};
  assign hdr_end   = {1'b0, data} + {1'b0, pfpp_pkg::HEADER_BYTES};
  assign fits      = (fit_end <= {1'b0, maxp});
  assign no_hdr    = (hdr_end > {1'b0, maxp});
  assign frag_full = (f_count >= 5'(pfpp_pkg::FRAGMENT_QUEUE_DEPTH));
  assign plen      = maxp - data - pfpp_pkg::HEADER_BYTES;

  assign pq_we = enq_go && p_ok;
  assign pq_wa = p_head + p_count[3:0];
  assign fq_we = step_fire && push_frag;
  assign fq_wa = f_head + f_count[3:0];

  // Registered reads of both queue heads.
  always_ff @(posedge clk) begin
    p_rd <= pq[p_head];
    f_rd <= fq[f_head];
    if (pq_we) pq[pq_wa] <= cmd.pkt;
    if (fq_we) fq[fq_wa] <= fq_wd;
  end

  // Classifies the entry at the head: fragments are served before packets.
  always_comb begin
    step_seg  = 1'b0;
    step_end  = 1'b1;
    pop_frag  = 1'b0;
    pop_pkt   = 1'b0;
    push_frag = 1'b0;
    fq_wd     = cur;
    seg               = '0;
    seg.segment_valid = 1'b1;
    seg.src_slot      = cur.slot;
    seg.src_offset    = cur.offset;
    seg.seg_length    = cur.len;
    seg.seg_id        = cur.id;
    seg.seg_frag_num  = cur.frag;
    seg.seg_last      = use_frag ? 1'b1 : cur.last;
    seg.dest_offset   = data;
    seg.bytes_used    = fit_end[15:0];
    seg.useful_size   = useful;
    if (room && have_item) begin
      if (fits) begin
        step_seg = 1'b1;
        step_end = 1'b0;
        pop_frag = use_frag;
        pop_pkt  = !use_frag;
      end else if (use_frag && no_hdr) begin
        // The fragment waits at the head of its queue for the next area.
      end else if (!use_frag && frag_full) begin
        // The packet stays where it is.
      end else if (no_hdr) begin
        pop_pkt   = 1'b1;
        push_frag = 1'b1;
      end else begin
        step_seg       = 1'b1;
        pop_frag       = use_frag;
        pop_pkt        = !use_frag;
        push_frag      = 1'b1;
        seg.seg_length = plen;
        seg.seg_last   = 1'b0;
        seg.bytes_used = maxp;
        fq_wd.len      = cur.len - plen;
        fq_wd.frag     = cur.frag + 8'd1;
        fq_wd.last     = 1'b0;
        fq_wd.offset   = cur.offset + plen;
      end
    end
  end

  // A segment is held back one step so that the final one of an item can be marked.
  always_comb begin
    res_next       = res;
    res_valid_next = res_valid && !out_ch.ready;
    pend_next      = pend;
    pend_full_next = pend_full;
    state_next     = state;
    case (state)
      S_IDLE: begin
        if (enq_go) begin
          res_next             = '0;
          res_next.accepted    = p_ok;
          res_next.last_result = 1'b1;
          res_valid_next       = 1'b1;
        end else if (asm_go) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_STEP;
      S_STEP: begin
        if (!res_valid) begin
          if (!step_end) begin
            if (pend_full) begin
              res_next       = pend;
              res_valid_next = 1'b1;
            end
            pend_next      = seg;
            pend_full_next = 1'b1;
            state_next     = S_READ;
          end else if (step_seg) begin
            if (pend_full) begin
              res_next              = pend;
              res_valid_next        = 1'b1;
              pend_next             = seg;
              pend_next.last_result = 1'b1;
              state_next            = S_FLUSH;
            end else begin
              res_next             = seg;
              res_next.last_result = 1'b1;
              res_valid_next       = 1'b1;
              state_next           = S_IDLE;
            end
          end else begin
            if (pend_full) begin
              res_next = pend;
            end else begin
              res_next             = '0;
              res_next.useful_size = useful;
            end
            res_next.last_result = 1'b1;
            res_valid_next       = 1'b1;
            pend_full_next       = 1'b0;
            state_next           = S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (!res_valid) begin
          res_next       = pend;
          res_valid_next = 1'b1;
          pend_full_next = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd_pop = enq_go || ((state != S_IDLE) && (state_next == S_IDLE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      p_head    <= '0;
      p_count   <= '0;
      f_head    <= '0;
      f_count   <= '0;
      res       <= '0;
      res_valid <= 1'b0;
      pend      <= '0;
      pend_full <= 1'b0;
      data      <= '0;
      maxp      <= '0;
      useful    <= '0;
    end else begin
      state     <= state_next;
      res       <= res_next;
      res_valid <= res_valid_next;
      pend      <= pend_next;
      pend_full <= pend_full_next;
      if (pq_we) p_count <= p_count + 5'd1;
      if (asm_go) begin
        data <= '0;
        if (cmd.psize >= min_partition_size) begin
          useful <= (cmd.psize >= 16'd4) ? cmd.psize - 16'd4 : 16'd0;
          maxp   <= (cmd.psize >= 16'd6) ? cmd.psize - 16'd6 : 16'd0;
        end else begin
          useful <= '0;
          maxp   <= '0;
        end
      end
      if (step_fire) begin
        if (pop_pkt) begin
          p_head  <= p_head + 4'd1;
          p_count <= p_count - 5'd1;
        end
        f_head  <= f_head + {3'd0, pop_frag};
        f_count <= f_count + {4'd0, push_frag} - {4'd0, pop_frag};
        if (!step_end) data <= fit_end[15:0];
      end
    end
  end

  a_pkt_bound: assert property (@(posedge clk) disable iff (rst)
    p_count <= 5'(pfpp_pkg::PACKET_QUEUE_DEPTH)) else $error("packet queue overflow");
  a_frag_bound: assert property (@(posedge clk) disable iff (rst)
    f_count <= 5'(pfpp_pkg::FRAGMENT_QUEUE_DEPTH)) else $error("fragment queue overflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_ch.ready) |=> (res_valid && $stable(res)))
    else $error("result dropped or changed while waiting");
  a_flush_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> pend_full) else $error("flush with no held segment");

endmodule

[rtl/core/packet_fragmenting_payload_packer.sv]
// Packet fragmenting payload packer: enqueues packet descriptors and, per assemble
// command, emits segment descriptors, fragments first. A command is registered in the
// front queue; an enqueue then writes its result to the output register. An assemble
// takes a set-up step and then, for every queue entry it visits, a read state for the
// registered read of the queue heads and a step state, plus a flush state to release a
// held final segment; receiver stalls add to this.
// Depends on pfpp_pkg, pfpp_if.
module packet_fragmenting_payload_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  pfpp_in_if.sink     in_ch,
  pfpp_out_if.source  out_ch
);

  logic [4:0]  pkt_limit;
  logic [15:0] min_partition_size;
  logic        cmd_valid;
  logic        cmd_pop;
  pfpp_pkg::cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_limit          <= 5'd16;
      min_partition_size <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        pfpp_pkg::REG_PKT_LIMIT:     pkt_limit <= cfg_data[4:0];
        pfpp_pkg::REG_MIN_PARTITION: min_partition_size <= cfg_data;
        default: ;
      endcase
    end
  end

  pfpp_front u_front (
    .clk, .rst, .in_ch, .cmd_valid, .cmd, .cmd_pop
  );

  pfpp_back u_back (
    .clk, .rst, .pkt_limit, .min_partition_size, .cmd_valid, .cmd, .cmd_pop, .out_ch
  );

endmodule

[dv/pfpp_tb_if.sv]
// Constants shared by the packer testbench.
// No dependencies; the channel interfaces come from the block's own interface file.
package pfpp_tb_pkg;

  localparam int HDR        = 8;
  localparam int IDLE_LIMIT = 20000;

endpackage

[dv/tb.sv]
// Testbench for the packet fragmenting payload packer: drives enqueue and assemble
// transfers with random gaps and stalls, predicts every segment descriptor and compares.
// Depends on pfpp_pkg, pfpp_tb_pkg, the channel interfaces and the packer RTL.
module tb;

  localparam int PKT_DEPTH  = pfpp_pkg::PACKET_QUEUE_DEPTH;
  localparam int FRAG_DEPTH = pfpp_pkg::FRAGMENT_QUEUE_DEPTH;
  localparam int HDR        = pfpp_tb_pkg::HDR;
  localparam int IDLE_LIMIT = pfpp_tb_pkg::IDLE_LIMIT;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pfpp_in_if  in_ch ();
  pfpp_out_if out_ch ();

  packet_fragmenting_payload_packer u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always #10 clk = ~clk;

  // Predicted state of the packer.
  pfpp_pkg::entry_t pkt_q [PKT_DEPTH];
  pfpp_pkg::entry_t frag_q [FRAG_DEPTH];
  int unsigned pkt_head, pkt_cnt, frag_head, frag_cnt;
  int unsigned lim_reg, min_part_reg;

  pfpp_pkg::result_t expected_segments [$];
  int unsigned n_errors;
  int unsigned idle_cycles;
  logic        sink_stall_en;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = pfpp_pkg::OP_ENQUEUE;
    in_ch.pkt_length = '0;
    in_ch.pkt_id = '0;
    in_ch.pkt_frag_num = '0;
    in_ch.pkt_last = 1'b0;
    in_ch.pkt_slot = '0;
    in_ch.partition_size = '0;
    sink_stall_en = 1'b1;
  end

  function automatic pfpp_pkg::result_t make_seg(pfpp_pkg::entry_t e, int unsigned len,
                                                 logic lst, int unsigned dst,
                                                 int unsigned used, int unsigned usef);
    pfpp_pkg::result_t r;
    r = '0;
    r.segment_valid = 1'b1;
    r.src_slot = e.slot;
    r.src_offset = e.offset;
    r.seg_length = len[15:0];
    r.seg_id = e.id;
    r.seg_frag_num = e.frag;
    r.seg_last = lst;
    r.dest_offset = dst[15:0];
    r.bytes_used = used[15:0];
    r.useful_size = usef[15:0];
    return r;
  endfunction

  function automatic void expect_result(pfpp_pkg::result_t r);
    expected_segments.insert(expected_segments.size(), r);
  endfunction

  function automatic void frag_append(pfpp_pkg::entry_t e);
    frag_q[(frag_head + frag_cnt) % FRAG_DEPTH] = e;
    frag_cnt++;
  endfunction

  // Works out the descriptors for one accepted item and updates the queues.
  task automatic predict_packing(logic op, pfpp_pkg::entry_t pkt, logic [15:0] psize);
    pfpp_pkg::result_t r;
    pfpp_pkg::entry_t  e, rem;
    int unsigned usef, maxp, data, plen, n;
    logic        done;
    n = 0;
    data = 0;
    usef = 0;
    if (op == pfpp_pkg::OP_ENQUEUE) begin
      r = '0;
      r.last_result = 1'b1;
      if (pkt_cnt < lim_reg && pkt_cnt < PKT_DEPTH) begin
        pkt.offset = '0;
        pkt_q[(pkt_head + pkt_cnt) % PKT_DEPTH] = pkt;
        pkt_cnt++;
        r.accepted = 1'b1;
      end
      expect_result(r);
      return;
    end
    if (psize >= min_part_reg) begin
      usef = (psize >= 4) ? psize - 4 : 0;
      maxp = (psize >= 6) ? psize - 6 : 0;
      done = 1'b0;
      while (!done && data < maxp) begin
        if (frag_cnt > 0) begin
          e = frag_q[frag_head];
          if (data + e.len + HDR <= maxp) begin
            expect_result(make_seg(e, e.len, 1'b1, data, data + e.len + HDR, usef));
            n++;
            data += e.len + HDR;
            frag_head = (frag_head + 1) % FRAG_DEPTH;
            frag_cnt--;
          end else if (data + HDR > maxp) begin
            done = 1'b1;
          end else begin
            plen = maxp - data - HDR;
            expect_result(make_seg(e, plen, 1'b0, data, maxp, usef));
            n++;
            rem = e;
            rem.len = 16'(e.len - plen);
            rem.frag = e.frag + 8'd1;
            rem.last = 1'b0;
            rem.offset = e.offset + plen[15:0];
            frag_head = (frag_head + 1) % FRAG_DEPTH;
            frag_cnt--;
            frag_append(rem);
            done = 1'b1;
          end
        end else if (pkt_cnt > 0) begin
          e = pkt_q[pkt_head];
          if (data + e.len + HDR <= maxp) begin
            expect_result(make_seg(e, e.len, e.last, data, data + e.len + HDR, usef));
            n++;
            data += e.len + HDR;
            pkt_head = (pkt_head + 1) % PKT_DEPTH;
            pkt_cnt--;
          end else if (frag_cnt >= FRAG_DEPTH) begin
            done = 1'b1;
          end else if (data + HDR > maxp) begin
            frag_append(e);
            pkt_head = (pkt_head + 1) % PKT_DEPTH;
            pkt_cnt--;
            done = 1'b1;
          end else begin
            plen = maxp - data - HDR;
            expect_result(make_seg(e, plen, 1'b0, data, maxp, usef));
            n++;
            rem = e;
            rem.len = 16'(e.len - plen);
            rem.frag = e.frag + 8'd1;
            rem.last = 1'b0;
            rem.offset = e.offset + plen[15:0];
            frag_append(rem);
            pkt_head = (pkt_head + 1) % PKT_DEPTH;
            pkt_cnt--;
            done = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
    end
    if (n == 0) begin
      r = '0;
      r.useful_size = usef[15:0];
      expect_result(r);
    end
    r = expected_segments[expected_segments.size() - 1];
    r.last_result = 1'b1;
    expected_segments[expected_segments.size() - 1] = r;
  endtask

  // Sends one item; the prediction is made at the edge where the transfer happens.
  task automatic send_item(logic op, logic [15:0] len, logic [31:0] id, logic [7:0] frag,
                           logic lst, logic [3:0] slot, logic [15:0] psize);
    pfpp_pkg::entry_t e;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pkt_length <= len;
    in_ch.pkt_id <= id;
    in_ch.pkt_frag_num <= frag;
    in_ch.pkt_last <= lst;
    in_ch.pkt_slot <= slot;
    in_ch.partition_size <= psize;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    e = '0;
    e.len = len;
    e.id = id;
    e.frag = frag;
    e.last = lst;
    e.slot = slot;
    predict_packing(op, e, psize);
  endtask

  task automatic pause_sender(int unsigned cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic enqueue(logic [15:0] len);
    send_item(pfpp_pkg::OP_ENQUEUE, len, $urandom, 8'($urandom), 1'($urandom),
              4'($urandom), 16'($urandom));
  endtask

  task automatic assemble(logic [15:0] psize);
    send_item(pfpp_pkg::OP_ASSEMBLE, 16'($urandom), $urandom, 8'($urandom), 1'($urandom),
              4'($urandom), psize);
  endtask

  // Waits for every expected result plus the block's latency before a register write.
  task automatic drain_and_configure(logic [2:0] idx, logic [15:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pfpp_pkg::REG_PKT_LIMIT) lim_reg = val[4:0];
    else min_part_reg = val;
  endtask

  task automatic test_directed;
    enqueue(16'd0);
    enqueue(16'd65535);
    send_item(pfpp_pkg::OP_ENQUEUE, 16'd4, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'hF, 16'hFFFF);
    send_item(pfpp_pkg::OP_ENQUEUE, 16'd3, 32'h0, 8'h00, 1'b0, 4'h0, 16'h0);
    assemble(16'd19);               // below the minimum
    assemble(16'd22);               // zero-length packet fits whole, then a zero-length split
    assemble(16'd28);               // split of the large packet
    assemble(16'd20);               // another split of the remainder
    pause_sender(3);
    assemble(16'd65535);            // the remainder fits whole
    assemble(16'd25);
    assemble(16'd65535);
    assemble(16'd0);
  endtask

  task automatic test_queue_limits;
    int unsigned k;
    drain_and_configure(pfpp_pkg::REG_PKT_LIMIT, 16'd1);
    enqueue(16'd2);
    enqueue(16'd2);                 // refused at the limit
    drain_and_configure(pfpp_pkg::REG_PKT_LIMIT, 16'd16);
    for (k = 0; k < 18; k++) enqueue(16'(200 + k));
    // Small partitions move the head packet into the fragment queue, where it then blocks the rest.
    drain_and_configure(pfpp_pkg::REG_MIN_PARTITION, 16'd8);
    for (k = 0; k < 18; k++) assemble(16'd10);
    assemble(16'd65535);
    assemble(16'd65535);
  endtask

  task automatic test_tiny_partition;
    drain_and_configure(pfpp_pkg::REG_MIN_PARTITION, 16'd0);
    enqueue(16'd1);
    assemble(16'd0);
    assemble(16'd5);
    assemble(16'd6);
    assemble(16'd15);
    assemble(16'd100);
  endtask

  task automatic test_random_traffic;
    int unsigned k, burst, mode;
    for (k = 0; k < 270; k++) begin
      if (k % 75 == 0) begin
        drain_and_configure(pfpp_pkg::REG_PKT_LIMIT, 16'($urandom_range(1, 16)));
        drain_and_configure(pfpp_pkg::REG_MIN_PARTITION, (k == 150) ? 16'hFFFF :
                            16'($urandom_range(8, 60)));
        sink_stall_en = (k != 75);
      end
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        if ($urandom_range(0, 7) == 0) enqueue(16'($urandom));
        else enqueue(16'($urandom_range(0, 120)));
      end else if (mode < 9) begin
        assemble(16'($urandom_range(0, 300)));
      end else begin
        assemble(16'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 6);
        pause_sender(burst);
      end
    end
  endtask

  // Receiver stall pattern and result comparison.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= sink_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    pfpp_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_segments.size() == 0) begin
        $error("unexpected result transfer");
        n_errors++;
      end else begin
        want = expected_segments[0];
        expected_segments.delete(0);
        if (out_ch.segment_valid !== want.segment_valid) begin
          $error("segment_valid exp %0d got %0d", want.segment_valid, out_ch.segment_valid);
          n_errors++;
        end
        if (out_ch.src_slot !== want.src_slot) begin
          $error("src_slot exp %0d got %0d", want.src_slot, out_ch.src_slot);
          n_errors++;
        end
        if (out_ch.src_offset !== want.src_offset) begin
          $error("src_offset exp %0d got %0d", want.src_offset, out_ch.src_offset);
          n_errors++;
        end
        if (out_ch.seg_length !== want.seg_length) begin
          $error("seg_length exp %0d got %0d", want.seg_length, out_ch.seg_length);
          n_errors++;
        end
        if (out_ch.seg_id !== want.seg_id) begin
          $error("seg_id exp %0h got %0h", want.seg_id, out_ch.seg_id);
          n_errors++;
        end
        if (out_ch.seg_frag_num !== want.seg_frag_num) begin
          $error("seg_frag_num exp %0d got %0d", want.seg_frag_num, out_ch.seg_frag_num);
          n_errors++;
        end
        if (out_ch.seg_last !== want.seg_last) begin
          $error("seg_last exp %0d got %0d", want.seg_last, out_ch.seg_last);
          n_errors++;
        end
        if (out_ch.dest_offset !== want.dest_offset) begin
          $error("dest_offset exp %0d got %0d", want.dest_offset, out_ch.dest_offset);
          n_errors++;
        end
        if (out_ch.bytes_used !== want.bytes_used) begin
          $error("bytes_used exp %0d got %0d", want.bytes_used, out_ch.bytes_used);
          n_errors++;
        end
        if (out_ch.useful_size !== want.useful_size) begin
          $error("useful_size exp %0d got %0d", want.useful_size, out_ch.useful_size);
          n_errors++;
        end
        if (out_ch.accepted !== want.accepted) begin
          $error("accepted exp %0d got %0d", want.accepted, out_ch.accepted);
          n_errors++;
        end
        if (out_ch.last_result !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, out_ch.last_result);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    n_errors = 0;
    pkt_head = 0;
    pkt_cnt = 0;
    frag_head = 0;
    frag_cnt = 0;
    lim_reg = 16;
    min_part_reg = 20;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_queue_limits();
    test_tiny_partition();
    test_random_traffic();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/pfpp_pkg.sv
rtl/core/pfpp_if.sv
rtl/core/pfpp_front.sv
rtl/core/pfpp_back.sv
rtl/core/packet_fragmenting_payload_packer.sv
dv/pfpp_tb_if.sv
dv/tb.sv
